FILE: src/polygon_perimeter_area_macros.svh
// Assertion macros for the polygon perimeter and area block.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef POLYGON_PERIMETER_AREA_MACROS_SVH
`define POLYGON_PERIMETER_AREA_MACROS_SVH

// Checked on every rising edge outside reset
`define PPA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every rising edge, reset included
`define PPA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/ppa_pkg.sv
// Shared widths, constants, datapath operation codes and the
// controller/datapath interface structs. No dependencies.
`default_nettype none

package ppa_pkg;

    localparam int unsigned COORD_W     = 24;
    localparam int unsigned DIFF_W      = 25;
    localparam int unsigned PROD_W      = 50;
    localparam int unsigned RAD_W       = 52;
    localparam int unsigned ROOT_W      = 26;
    localparam int unsigned REM_W       = 27;
    localparam int unsigned LEN_W       = 40;
    localparam int unsigned CROSS_W     = 59;
    localparam int unsigned AREA_W      = 58;
    localparam int unsigned CNT_W       = 11;
    localparam int unsigned MAX_NODES   = 1024;
    localparam int unsigned SQRT_STEPS  = 26;
    localparam int unsigned SQRT_CNT_W  = 5;

    localparam int unsigned IN_TDATA_W  = 72;
    localparam int unsigned OUT_TDATA_W = 112;
    localparam int unsigned TOTAL_LSB   = LEN_W + AREA_W;

    localparam logic signed [CROSS_W:0] CROSS_LIM     = {2'b00, {AREA_W{1'b1}}};
    localparam logic signed [CROSS_W:0] CROSS_NEG_LIM = -CROSS_LIM;

    localparam logic [3:0] OP_IDLE   = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_DIFF   = 4'd2;
    localparam logic [3:0] OP_MUL_X  = 4'd3;
    localparam logic [3:0] OP_MUL_Y  = 4'd4;
    localparam logic [3:0] OP_MUL_Z  = 4'd5;
    localparam logic [3:0] OP_MUL_C1 = 4'd6;
    localparam logic [3:0] OP_MUL_C2 = 4'd7;
    localparam logic [3:0] OP_CROSS  = 4'd8;
    localparam logic [3:0] OP_SQRT   = 4'd9;
    localparam logic [3:0] OP_LEN    = 4'd10;
    localparam logic [3:0] OP_UPDATE = 4'd11;
    localparam logic [3:0] OP_RESULT = 4'd12;

    typedef struct packed {
        logic [3:0] op;
        logic       close;
    } ppa_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic last;
        logic close_ok;
        logic out_full;
    } ppa_status_t;

endpackage

`default_nettype wire

FILE: src/ppa_dp.sv
// Datapath: node registers, shared multiplier, digit-recurrence square root,
// saturating accumulators and the result register. Depends on ppa_pkg.
`default_nettype none

module ppa_dp
    import ppa_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic                   cfg_data,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                   s_axis_tlast,
    input  wire ppa_cmd_t               cmd,
    output ppa_status_t                 status,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                        m_axis_tuser
);

    logic                        closed_loop_reg;
    logic signed [COORD_W-1:0]   cur_x_reg, cur_y_reg, cur_z_reg;
    logic                        cur_last_reg;
    logic signed [COORD_W-1:0]   first_x_reg, first_y_reg, first_z_reg;
    logic signed [COORD_W-1:0]   prev_x_reg, prev_y_reg, prev_z_reg;
    logic signed [DIFF_W-1:0]    dx_reg, dy_reg, dz_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [PROD_W-1:0]    cross_a_reg;
    logic [PROD_W-1:0]           sq_sum_reg;
    logic [RAD_W-1:0]            rad_reg;
    logic [REM_W-1:0]            rem_reg;
    logic [ROOT_W-1:0]           root_reg;
    logic [LEN_W-1:0]            length_sum_reg;
    logic signed [CROSS_W-1:0]   cross_sum_reg;
    logic [CNT_W-1:0]            node_count_reg;
    logic                        saturated_reg;
    logic                        out_valid_reg;
    logic [LEN_W-1:0]            perimeter_reg;
    logic [AREA_W-1:0]           area_reg;
    logic [CNT_W-1:0]            total_reg;
    logic                        ovf_reg;

    logic signed [COORD_W-1:0]   tgt_x, tgt_y, tgt_z;
    logic signed [DIFF_W-1:0]    mul_a, mul_b;
    logic signed [PROD_W-1:0]    mul_p;
    logic signed [PROD_W-1:0]    cross_term;
    logic signed [CROSS_W:0]     cross_wide;
    logic signed [CROSS_W-1:0]   cross_sum_next;
    logic                        cross_sat;
    logic [REM_W+1:0]            rem_try;
    logic [REM_W+1:0]            trial;
    logic [REM_W+1:0]            rem_diff;
    logic                        root_bit;
    logic [ROOT_W:0]             root_inc;
    logic [LEN_W:0]              len_wide;
    logic [LEN_W-1:0]            length_sum_next;
    logic signed [CROSS_W-1:0]   cross_abs;
    logic [AREA_W-1:0]           area_val;

    assign tgt_x = cmd.close ? first_x_reg : cur_x_reg;
    assign tgt_y = cmd.close ? first_y_reg : cur_y_reg;
    assign tgt_z = cmd.close ? first_z_reg : cur_z_reg;

    always_comb
    begin
        unique case (cmd.op)
            OP_MUL_Y:
            begin
                mul_a = dy_reg;
                mul_b = dy_reg;
            end
            OP_MUL_Z:
            begin
                mul_a = dz_reg;
                mul_b = dz_reg;
            end
            OP_MUL_C1:
            begin
                mul_a = DIFF_W'(prev_x_reg);
                mul_b = DIFF_W'(tgt_y);
            end
            OP_MUL_C2:
            begin
                mul_a = DIFF_W'(tgt_x);
                mul_b = DIFF_W'(prev_y_reg);
            end
            default:
            begin
                mul_a = dx_reg;
                mul_b = dx_reg;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign cross_term = cross_a_reg - prod_reg;
    assign cross_wide = (CROSS_W + 1)'(cross_sum_reg) + (CROSS_W + 1)'(cross_term);

    always_comb
    begin
        cross_sat = 1'b0;
        cross_sum_next = CROSS_W'(cross_wide);
        if (cross_wide > CROSS_LIM)
        begin
            cross_sum_next = CROSS_W'(CROSS_LIM);
            cross_sat = 1'b1;
        end
        else if (cross_wide < CROSS_NEG_LIM)
        begin
            cross_sum_next = CROSS_W'(CROSS_NEG_LIM);
            cross_sat = 1'b1;
        end
    end

    assign rem_try  = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial    = {1'b0, root_reg, 2'b01};
    assign root_bit = (rem_try >= trial);
    assign rem_diff = rem_try - trial;

    assign root_inc        = {1'b0, root_reg} + (ROOT_W + 1)'(1);
    assign len_wide        = (LEN_W + 1)'(length_sum_reg) + (LEN_W + 1)'(root_inc[ROOT_W:1]);
    assign length_sum_next = len_wide[LEN_W] ? {LEN_W{1'b1}} : len_wide[LEN_W-1:0];

    assign cross_abs = cross_sum_reg[CROSS_W-1] ? -cross_sum_reg : cross_sum_reg;
    assign area_val  = status.close_ok ? cross_abs[AREA_W-1:0] : '0;

    assign status.count_zero = (node_count_reg == '0);
    assign status.last       = cur_last_reg;
    assign status.close_ok   = closed_loop_reg && (node_count_reg > CNT_W'(2));
    assign status.out_full   = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closed_loop_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            closed_loop_reg <= cfg_data;
        end
    end

    // Working registers and result payload
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                cur_x_reg    <= s_axis_tdata[COORD_W-1:0];
                cur_y_reg    <= s_axis_tdata[2*COORD_W-1:COORD_W];
                cur_z_reg    <= s_axis_tdata[3*COORD_W-1:2*COORD_W];
                cur_last_reg <= s_axis_tlast;
            end
            OP_DIFF:
            begin
                dx_reg <= DIFF_W'(tgt_x) - DIFF_W'(prev_x_reg);
                dy_reg <= DIFF_W'(tgt_y) - DIFF_W'(prev_y_reg);
                dz_reg <= DIFF_W'(tgt_z) - DIFF_W'(prev_z_reg);
            end
            OP_MUL_X:
            begin
                prod_reg <= mul_p;
            end
            OP_MUL_Y:
            begin
                sq_sum_reg <= prod_reg;
                prod_reg   <= mul_p;
            end
            OP_MUL_Z:
            begin
                sq_sum_reg <= sq_sum_reg + prod_reg;
                prod_reg   <= mul_p;
            end
            OP_MUL_C1:
            begin
                sq_sum_reg <= sq_sum_reg + prod_reg;
                prod_reg   <= mul_p;
            end
            OP_MUL_C2:
            begin
                cross_a_reg <= prod_reg;
                prod_reg    <= mul_p;
                rad_reg     <= {sq_sum_reg, 2'b00};
                rem_reg     <= '0;
                root_reg    <= '0;
            end
            OP_SQRT:
            begin
                rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                rem_reg  <= root_bit ? rem_diff[REM_W-1:0] : rem_try[REM_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], root_bit};
            end
            OP_RESULT:
            begin
                perimeter_reg <= length_sum_reg;
                area_reg      <= area_val;
                total_reg     <= node_count_reg;
                ovf_reg       <= saturated_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Contour state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_x_reg    <= '0;
            first_y_reg    <= '0;
            first_z_reg    <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            prev_z_reg     <= '0;
            length_sum_reg <= '0;
            cross_sum_reg  <= '0;
            node_count_reg <= '0;
            saturated_reg  <= 1'b0;
        end
        else
        begin
            unique case (cmd.op)
                OP_CROSS:
                begin
                    cross_sum_reg <= cross_sum_next;
                    if (cross_sat)
                    begin
                        saturated_reg <= 1'b1;
                    end
                end
                OP_LEN:
                begin
                    length_sum_reg <= length_sum_next;
                    if (len_wide[LEN_W])
                    begin
                        saturated_reg <= 1'b1;
                    end
                end
                OP_UPDATE:
                begin
                    if (node_count_reg == '0)
                    begin
                        first_x_reg <= cur_x_reg;
                        first_y_reg <= cur_y_reg;
                        first_z_reg <= cur_z_reg;
                    end
                    prev_x_reg <= cur_x_reg;
                    prev_y_reg <= cur_y_reg;
                    prev_z_reg <= cur_z_reg;
                    if (node_count_reg < CNT_W'(MAX_NODES))
                    begin
                        node_count_reg <= node_count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        saturated_reg <= 1'b1;
                    end
                end
                OP_RESULT:
                begin
                    first_x_reg    <= '0;
                    first_y_reg    <= '0;
                    first_z_reg    <= '0;
                    prev_x_reg     <= '0;
                    prev_y_reg     <= '0;
                    prev_z_reg     <= '0;
                    length_sum_reg <= '0;
                    cross_sum_reg  <= '0;
                    node_count_reg <= '0;
                    saturated_reg  <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_RESULT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, total_reg, area_reg, perimeter_reg};
    assign m_axis_tuser  = ovf_reg;

endmodule

`default_nettype wire

FILE: src/ppa_ctrl.sv
// Controller: sequences one node through difference, multiply, root and
// accumulate steps, then the closing segment and the result. Depends on ppa_pkg.
`default_nettype none

module ppa_ctrl
    import ppa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire ppa_status_t status,
    output ppa_cmd_t         cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DIFF   = 4'd1;
    localparam logic [3:0] S_MUL_X  = 4'd2;
    localparam logic [3:0] S_MUL_Y  = 4'd3;
    localparam logic [3:0] S_MUL_Z  = 4'd4;
    localparam logic [3:0] S_MUL_C1 = 4'd5;
    localparam logic [3:0] S_MUL_C2 = 4'd6;
    localparam logic [3:0] S_CROSS  = 4'd7;
    localparam logic [3:0] S_SQRT   = 4'd8;
    localparam logic [3:0] S_LEN    = 4'd9;
    localparam logic [3:0] S_UPDATE = 4'd10;
    localparam logic [3:0] S_DECIDE = 4'd11;
    localparam logic [3:0] S_RESULT = 4'd12;

    logic [3:0]            state_reg, state_next;
    logic                  close_reg, close_next;
    logic [SQRT_CNT_W-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            close_reg <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            close_reg <= close_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        close_next = close_reg;
        step_next  = step_reg;
        cmd.op     = OP_IDLE;
        cmd.close  = close_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = status.count_zero ? S_UPDATE : S_DIFF;
                end
            end
            S_DIFF:
            begin
                cmd.op     = OP_DIFF;
                state_next = S_MUL_X;
            end
            S_MUL_X:
            begin
                cmd.op     = OP_MUL_X;
                state_next = S_MUL_Y;
            end
            S_MUL_Y:
            begin
                cmd.op     = OP_MUL_Y;
                state_next = S_MUL_Z;
            end
            S_MUL_Z:
            begin
                cmd.op     = OP_MUL_Z;
                state_next = S_MUL_C1;
            end
            S_MUL_C1:
            begin
                cmd.op     = OP_MUL_C1;
                state_next = S_MUL_C2;
            end
            S_MUL_C2:
            begin
                cmd.op     = OP_MUL_C2;
                state_next = S_CROSS;
            end
            S_CROSS:
            begin
                cmd.op     = OP_CROSS;
                step_next  = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op = OP_SQRT;
                if (step_reg == SQRT_CNT_W'(SQRT_STEPS - 1))
                begin
                    state_next = S_LEN;
                end
                else
                begin
                    step_next = step_reg + SQRT_CNT_W'(1);
                end
            end
            S_LEN:
            begin
                cmd.op     = OP_LEN;
                state_next = close_reg ? S_RESULT : S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.op     = OP_UPDATE;
                state_next = status.last ? S_DECIDE : S_IDLE;
            end
            S_DECIDE:
            begin
                if (status.close_ok)
                begin
                    close_next = 1'b1;
                    state_next = S_DIFF;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!status.out_full)
                begin
                    cmd.op     = OP_RESULT;
                    close_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (state_reg == S_IDLE);

endmodule

`default_nettype wire

FILE: src/polygon_perimeter_area.sv
// Polygon perimeter and shoelace area. A node beat is worked to the end before
// the next is taken; a contour's first node has no segment. The 26-step square
// root of each segment dominates. A last node adds the closing segment. Results
// go out when the output is free; nodes are taken while a result waits there.
// rst_n clears the contour, the closed_loop register and the output valid.
`default_nettype none

module polygon_perimeter_area
    import ppa_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic                   cfg_data,       // closed_loop
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // x_coord, y_coord, z_coord
    input  wire logic                   s_axis_tlast,   // last_node
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // perimeter, area, node_total, pad
    output logic                        m_axis_tuser    // overflow
);

    ppa_cmd_t    cmd;
    ppa_status_t status;

    ppa_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    ppa_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .cmd           (cmd),
        .status        (status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

FILE: src/ppa_checker.sv
// Port checker for polygon_perimeter_area, bound to the top level.
// Depends on ppa_pkg and polygon_perimeter_area_macros.svh.
`default_nettype none
`include "polygon_perimeter_area_macros.svh"

module ppa_checker
    import ppa_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                   m_axis_tuser
);

    logic [CNT_W-1:0] total;

    assign total = m_axis_tdata[TOTAL_LSB +: CNT_W];

    `PPA_ASSERT(a_result_holds, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed while stalled")
    `PPA_ASSERT(a_busy_after_node, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "node beat taken while a node is in work")
    `PPA_ASSERT(a_count_range, m_axis_tvalid |-> total != '0 && total <= CNT_W'(MAX_NODES), "node total out of range")
    `PPA_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !m_axis_tvalid, "result valid during reset")

endmodule

bind polygon_perimeter_area ppa_checker u_ppa_checker (.*);

`default_nettype wire
